>>> rtl/core/mpct_pkg.sv
package mpct_pkg;

    // Cursor coordinate width, default for the top-level parameter
    localparam int COORD_BITS_DEFAULT = 12;

    // Field widths fixed by the packet format and register map
    localparam int CFG_DATA_BITS  = 13;
    localparam int TIMEOUT_BITS   = 8;
    localparam int BYTE_BITS      = 8;
    localparam int BUTTON_BITS    = 3;
    localparam int DELTA_X_BITS   = 9;
    localparam int DELTA_Y_BITS   = 10;
    localparam int CFG_INDEX_BITS = 2;

    // Header byte layout
    localparam int HDR_SYNC_BIT   = 3;
    localparam int HDR_X_SIGN_BIT = 4;
    localparam int HDR_Y_SIGN_BIT = 5;

    localparam logic [TIMEOUT_BITS-1:0] IDLE_MAX = '1;

    // Register reset values
    localparam logic [CFG_DATA_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
    localparam logic [CFG_DATA_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd768;
    localparam logic [TIMEOUT_BITS-1:0]  TIMEOUT_RESET       = 8'd20;

    // Input item kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_TIMEOUT_TICKS = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_X_MOVE = 2'd1,
        PH_Y_MOVE = 2'd2
    } phase_t;

    // Completed-packet report from the assembler
    typedef struct packed {
        logic                    done;
        logic [BUTTON_BITS-1:0]  buttons;
        logic [DELTA_X_BITS-1:0] dx;
        logic [DELTA_Y_BITS-1:0] dy;
    } pkt_t;

endpackage

>>> rtl/core/mouse_packet_cursor_tracker.sv
// Mouse packet cursor tracker. Each input item is either a byte received from
// the mouse (s_cmd = 0) or one timer tick (s_cmd = 1). Three-byte packets are
// assembled: a header byte is taken only with bit 3 set, and a partial packet
// is abandoned when a byte arrives after more than timeout_ticks idle ticks.
// Each completed packet yields one result item with the buttons, the signed
// deltas (vertical negated to screen direction) and the cursor after it is
// moved and clamped to 0 .. screen size - 1. Ticks, dropped bytes and the first
// two packet bytes yield nothing. An item enters an input register and is
// processed from there into the result register, so one item is taken
// every cycle; a pending result only holds back an item that completes a
// packet. Write configuration through the cfg_ port while no item is in flight.
module mouse_packet_cursor_tracker #(
    parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,

    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [mpct_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
    input  logic [mpct_pkg::CFG_DATA_BITS-1:0]          cfg_data,

    input  logic                                        s_valid,
    output logic                                        s_ready,
    input  logic                                        s_cmd,
    input  logic [mpct_pkg::BYTE_BITS-1:0]              s_data_byte,

    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic [mpct_pkg::BUTTON_BITS-1:0]            m_buttons,
    output logic signed [mpct_pkg::DELTA_X_BITS-1:0]    m_delta_x,
    output logic signed [mpct_pkg::DELTA_Y_BITS-1:0]    m_delta_y,
    output logic [COORD_BITS-1:0]                       m_cursor_x,
    output logic [COORD_BITS-1:0]                       m_cursor_y
);

    // Configuration registers
    logic [mpct_pkg::CFG_DATA_BITS-1:0] width_reg, height_reg;
    logic [mpct_pkg::TIMEOUT_BITS-1:0]  timeout_reg;

    // Input register
    logic                               in_valid_reg;
    logic                               in_cmd_reg;
    logic [mpct_pkg::BYTE_BITS-1:0]     in_data_reg;

    // Result register
    logic                               out_valid_reg;
    logic [mpct_pkg::BUTTON_BITS-1:0]   out_buttons_reg;
    logic [mpct_pkg::DELTA_X_BITS-1:0]  out_dx_reg;
    logic [mpct_pkg::DELTA_Y_BITS-1:0]  out_dy_reg;
    logic [COORD_BITS-1:0]              out_x_reg, out_y_reg;

    mpct_pkg::pkt_t                     pkt;
    logic                               fire;
    logic                               update;
    logic [COORD_BITS-1:0]              x_next, y_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= mpct_pkg::SCREEN_WIDTH_RESET;
            height_reg  <= mpct_pkg::SCREEN_HEIGHT_RESET;
            timeout_reg <= mpct_pkg::TIMEOUT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mpct_pkg::CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                mpct_pkg::CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                mpct_pkg::CFG_TIMEOUT_TICKS:
                    timeout_reg <= cfg_data[mpct_pkg::TIMEOUT_BITS-1:0];
                default: ;  // drop writes beyond the register map
            endcase
        end
    end

    // Process the held item unless it completes a packet while a result waits
    assign fire    = in_valid_reg && (!pkt.done || !out_valid_reg || m_ready);
    assign update  = fire && pkt.done;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_cmd;
            in_data_reg <= s_data_byte;
        end
    end

    mpct_assembler u_assembler (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .cmd           (in_cmd_reg),
        .data_byte     (in_data_reg),
        .timeout_ticks (timeout_reg),
        .pkt           (pkt)
    );

    mpct_axis #(
        .COORD_BITS (COORD_BITS),
        .DELTA_BITS (mpct_pkg::DELTA_X_BITS)
    ) u_axis_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .update   (update),
        .delta    ($signed(pkt.dx)),
        .size     (width_reg),
        .pos_next (x_next)
    );

    mpct_axis #(
        .COORD_BITS (COORD_BITS),
        .DELTA_BITS (mpct_pkg::DELTA_Y_BITS)
    ) u_axis_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .update   (update),
        .delta    ($signed(pkt.dy)),
        .size     (height_reg),
        .pos_next (y_next)
    );

    // Hold the result until taken; a completing packet refills it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (update) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (update) begin
            out_buttons_reg <= pkt.buttons;
            out_dx_reg      <= pkt.dx;
            out_dy_reg      <= pkt.dy;
            out_x_reg       <= x_next;
            out_y_reg       <= y_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_buttons  = out_buttons_reg;
    assign m_delta_x  = $signed(out_dx_reg);
    assign m_delta_y  = $signed(out_dy_reg);
    assign m_cursor_x = out_x_reg;
    assign m_cursor_y = out_y_reg;

endmodule

>>> rtl/core/mpct_assembler.sv
module mpct_assembler (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                fire,
    input  logic                                cmd,
    input  logic [mpct_pkg::BYTE_BITS-1:0]      data_byte,
    input  logic [mpct_pkg::TIMEOUT_BITS-1:0]   timeout_ticks,
    output mpct_pkg::pkt_t                      pkt
);

    mpct_pkg::phase_t                      phase_reg, phase_next, phase_eff;
    logic [mpct_pkg::BYTE_BITS-1:0]        header_reg, header_next;
    logic [mpct_pkg::BYTE_BITS-1:0]        x_byte_reg, x_byte_next;
    logic [mpct_pkg::TIMEOUT_BITS-1:0]     idle_reg, idle_next;
    logic [mpct_pkg::DELTA_X_BITS-1:0]     dy_raw;

    always_comb begin
        // Abandon a stale partial packet; an undefined phase waits for a header
        phase_eff = phase_reg;
        unique case (phase_reg)
            mpct_pkg::PH_HEADER: phase_eff = mpct_pkg::PH_HEADER;
            mpct_pkg::PH_X_MOVE,
            mpct_pkg::PH_Y_MOVE: begin
                if (idle_reg > timeout_ticks) begin
                    phase_eff = mpct_pkg::PH_HEADER;
                end
            end
            default: phase_eff = mpct_pkg::PH_HEADER;
        endcase

        // A byte that finds the packet expired drops it even if the byte is dropped too
        phase_next  = phase_eff;
        header_next = header_reg;
        x_byte_next = x_byte_reg;
        idle_next   = idle_reg;
        pkt.done    = 1'b0;

        if (cmd == mpct_pkg::CMD_TICK) begin
            phase_next = phase_reg;
            if (idle_reg != mpct_pkg::IDLE_MAX) begin
                idle_next = idle_reg + 1'b1;
            end
        end else begin
            unique case (phase_eff)
                mpct_pkg::PH_X_MOVE: begin
                    x_byte_next = data_byte;
                    phase_next  = mpct_pkg::PH_Y_MOVE;
                    idle_next   = '0;
                end
                mpct_pkg::PH_Y_MOVE: begin
                    phase_next = mpct_pkg::PH_HEADER;
                    idle_next  = '0;
                    pkt.done   = 1'b1;
                end
                default: begin
                    // Drop a header without the sync bit; header, X byte and idle count untouched
                    if (data_byte[mpct_pkg::HDR_SYNC_BIT]) begin
                        header_next = data_byte;
                        phase_next  = mpct_pkg::PH_X_MOVE;
                        idle_next   = '0;
                    end
                end
            endcase
        end

        pkt.buttons = header_reg[mpct_pkg::BUTTON_BITS-1:0];
        pkt.dx      = {header_reg[mpct_pkg::HDR_X_SIGN_BIT], x_byte_reg};
        dy_raw      = {header_reg[mpct_pkg::HDR_Y_SIGN_BIT], data_byte};
        pkt.dy      = -{dy_raw[mpct_pkg::DELTA_X_BITS-1], dy_raw};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= mpct_pkg::PH_HEADER;
            header_reg <= '0;
            x_byte_reg <= '0;
            idle_reg   <= '0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            x_byte_reg <= x_byte_next;
            idle_reg   <= idle_next;
        end
    end

endmodule

>>> rtl/core/mpct_axis.sv
module mpct_axis #(
    parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEFAULT,
    parameter int DELTA_BITS = mpct_pkg::DELTA_X_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 update,
    input  logic signed [DELTA_BITS-1:0]         delta,
    input  logic [mpct_pkg::CFG_DATA_BITS-1:0]   size,
    output logic [COORD_BITS-1:0]                pos_next
);

    localparam int SUM_BITS = ((COORD_BITS > DELTA_BITS) ? COORD_BITS : DELTA_BITS) + 2;
    localparam int LIM_BITS = ((COORD_BITS + 1) > mpct_pkg::CFG_DATA_BITS) ?
                              (COORD_BITS + 1) : mpct_pkg::CFG_DATA_BITS;
    localparam logic [LIM_BITS-1:0] LIM_MAX = LIM_BITS'(1) << COORD_BITS;

    logic [COORD_BITS-1:0]      pos_reg;
    logic [LIM_BITS-1:0]        size_ext, lim, lim_m1;
    logic signed [SUM_BITS-1:0] sum;

    always_comb begin
        size_ext = LIM_BITS'(size);
        if (size_ext == '0) begin
            lim = LIM_BITS'(1);
        end else if (size_ext > LIM_MAX) begin
            lim = LIM_MAX;
        end else begin
            lim = size_ext;
        end
        lim_m1 = lim - 1'b1;

        sum = $signed(SUM_BITS'({1'b0, pos_reg})) + SUM_BITS'(delta);

        if (sum < 0) begin
            pos_next = '0;
        end else if (LIM_BITS'(unsigned'(sum)) >= lim) begin
            pos_next = lim_m1[COORD_BITS-1:0];
        end else begin
            pos_next = sum[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (update) begin
            pos_reg <= pos_next;
        end
    end

endmodule
